@@ hw/rtl/fdmus_pkg.sv @@
// ----------------------------------------------------------------------------
// fdmus_pkg
// shared constants, pin tables and types for the flip-dot update sequencer
// ----------------------------------------------------------------------------
package fdmus_pkg;

	localparam int COLUMNS   = 5;
	localparam int ROWS      = 7;
	localparam int DOTS      = COLUMNS * ROWS;
	localparam int SLOT_W    = 4;
	localparam int DOT_IDX_W = 6;
	localparam int COL_W     = 3;
	localparam int ROW_W     = 3;
	localparam int PIN_W     = 5;
	localparam int WORD_W    = 32;
	localparam int TICK_W    = 16;
	localparam int ADDR_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// register selections carried in an address byte
	localparam logic [SLOT_W-1:0] SLOT_COMMIT = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_REDRAW = 4'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODULE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_TIME        = 2'd2;

	localparam logic [ADDR_W-1:0] MODULE_ADDRESS_RST = 3'd0;
	localparam logic [TICK_W-1:0] FLIP_PERIOD_RST    = 16'd5100;
	localparam logic [TICK_W-1:0] ON_TIME_RST        = 16'd5000;

	// column zero lit after reset
	localparam logic [DOTS-1:0] DISPLAYED_RST = DOTS'((1 << ROWS) - 1);
	localparam logic [DOTS-1:0] ALL_DOTS      = '1;

	// h-bridge pin tables
	localparam logic [PIN_W-1:0] ROW_HI_PIN [ROWS] = '{5'd1, 5'd2, 5'd3, 5'd20, 5'd19,
		5'd18, 5'd17};
	localparam logic [PIN_W-1:0] ROW_LO_PIN [ROWS] = '{5'd11, 5'd10, 5'd9, 5'd28, 5'd27,
		5'd25, 5'd26};
	localparam logic [PIN_W-1:0] COL_HI_PIN [COLUMNS] = '{5'd7, 5'd6, 5'd5, 5'd22, 5'd23};
	localparam logic [PIN_W-1:0] COL_LO_PIN [COLUMNS] = '{5'd15, 5'd14, 5'd13, 5'd30,
		5'd31};

	// command decoder status seen by the sequencer
	typedef struct packed {
		logic [DOTS-1:0] target_dots;
		logic            commit_pending;
		logic            force_all;
	} cmd_status_t;

	// column of a dot slot, slot below DOTS
	function automatic logic [COL_W-1:0] slot_col(input logic [DOT_IDX_W-1:0] slot);
		logic [COL_W-1:0] col;
		col = '0;
		for (int k = 1; k < COLUMNS; k++) begin
			if (slot >= DOT_IDX_W'(k * ROWS))
				col = COL_W'(k);
		end
		return col;
	endfunction

	function automatic logic [WORD_W-1:0] pin_bit(input logic [PIN_W-1:0] pin);
		return WORD_W'(1) << pin;
	endfunction

endpackage

@@ hw/rtl/flipdot_module_update_sequencer.sv @@
// ----------------------------------------------------------------------------
// flipdot_module_update_sequencer
// sequences dot updates of one 5x7 flip-dot module from serial bytes and ticks
// ----------------------------------------------------------------------------
// path: from input transfer to result transfer through the input register,
//   then state update and result register
// throughput: one item per cycle while the result register is not stalled, bounded by the single state-update pass
// reset: async active low; registers to their reset values, commit with full
//   redraw pending, no clearing pass
module flipdot_module_update_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [7:0]                           byte_value,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [fdmus_pkg::WORD_W-1:0]         drive_word,
	output logic                                 is_pulse,
	output logic                                 update_done,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fdmus_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdmus_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration registers
	logic [fdmus_pkg::ADDR_W-1:0] module_address_q;
	logic [fdmus_pkg::TICK_W-1:0] flip_period_q;
	logic [fdmus_pkg::TICK_W-1:0] on_time_q;

	// input stage
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// sequencer state
	logic [fdmus_pkg::DOTS-1:0]      displayed_q;
	logic [fdmus_pkg::DOTS-1:0]      change_q;
	logic [fdmus_pkg::DOTS-1:0]      pulse_q;
	logic                            sequencing_q;
	logic [fdmus_pkg::DOT_IDX_W-1:0] dot_index_q;
	logic [fdmus_pkg::TICK_W-1:0]    tick_count_q;

	// result register
	logic                            out_valid_q;
	logic [fdmus_pkg::WORD_W-1:0]    drive_word_q;
	logic                            is_pulse_q;
	logic                            update_done_q;

	fdmus_pkg::cmd_status_t          cmd_status;
	logic [fdmus_pkg::WORD_W-1:0]    slot_word;

	logic advance;
	logic tick_en;
	logic byte_en;
	logic take_commit;
	logic release_hit;
	logic last_slot;
	logic [fdmus_pkg::TICK_W-1:0] tick_dec;
	logic drive_hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= fdmus_pkg::MODULE_ADDRESS_RST;
			flip_period_q    <= fdmus_pkg::FLIP_PERIOD_RST;
			on_time_q        <= fdmus_pkg::ON_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fdmus_pkg::REG_MODULE_ADDRESS:
					module_address_q <= cfg_data[fdmus_pkg::ADDR_W-1:0];
				fdmus_pkg::REG_FLIP_PERIOD: flip_period_q <= cfg_data;
				fdmus_pkg::REG_ON_TIME:     on_time_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// the held item moves on whenever the result register is free or draining
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= byte_value;
		end
	end

	// item being processed this cycle
	assign tick_en = valid_s1 && advance && kind_s1;
	assign byte_en = valid_s1 && advance && !kind_s1;

	// idle tick with a commit pending takes the snapshot
	assign take_commit = tick_en && !sequencing_q && cmd_status.commit_pending;
	assign release_hit = tick_en && sequencing_q && (tick_count_q == '0);
	assign last_slot   = dot_index_q >= fdmus_pkg::DOT_IDX_W'(fdmus_pkg::DOTS);
	assign tick_dec    = tick_count_q - 1'b1;
	assign drive_hit   = tick_en && sequencing_q && (tick_count_q != '0) &&
		(tick_dec == on_time_q);

	fdmus_cmd u_cmd (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_en        (byte_en),
		.byte_value     (byte_s1),
		.module_address (module_address_q),
		.commit_take    (take_commit),
		.status         (cmd_status)
	);

	fdmus_word u_word (
		.dot_index    (dot_index_q),
		.change_mask  (change_q),
		.pulse_values (pulse_q),
		.word         (slot_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			displayed_q  <= fdmus_pkg::DISPLAYED_RST;
			change_q     <= '0;
			pulse_q      <= '0;
			sequencing_q <= 1'b0;
			dot_index_q  <= '0;
			tick_count_q <= '0;
		end else if (take_commit) begin
			change_q     <= cmd_status.force_all ? fdmus_pkg::ALL_DOTS :
				(displayed_q ^ cmd_status.target_dots);
			pulse_q      <= cmd_status.target_dots;
			displayed_q  <= cmd_status.target_dots;
			tick_count_q <= flip_period_q;
			dot_index_q  <= '0;
			sequencing_q <= 1'b1;
		end else if (release_hit) begin
			// end of slot: reload and release the coils
			tick_count_q <= flip_period_q;
			if (last_slot)
				sequencing_q <= 1'b0;
		end else if (tick_en && sequencing_q) begin
			tick_count_q <= tick_dec;
			if (drive_hit && !last_slot)
				dot_index_q <= dot_index_q + 1'b1;
		end
	end

	// result register, loaded whenever the item stage moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= release_hit || drive_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_word_q  <= drive_hit ? slot_word : '0;
			is_pulse_q    <= drive_hit;
			update_done_q <= release_hit && last_slot;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_word  = drive_word_q;
	assign is_pulse    = is_pulse_q;
	assign update_done = update_done_q;

	// the end of an update is always a release word
	a_done_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && update_done_q) |-> (!is_pulse_q && drive_word_q == '0))
		else $error("update_done on a drive word");

	// slot walk never runs beyond index DOTS, one slot past the last dot
	a_dot_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dot_index_q <= fdmus_pkg::DOT_IDX_W'(fdmus_pkg::DOTS))
		else $error("dot index beyond last slot");

	// the final release stops the sequencer
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(release_hit && last_slot) |=> (!sequencing_q && out_valid_q && update_done_q))
		else $error("sequencer kept running after the final release");

	// a snapshot always starts the slot walk from the first dot
	a_commit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take_commit |=> (sequencing_q && dot_index_q == '0 && !cmd_status.force_all))
		else $error("commit did not start the sequencer");

endmodule

@@ hw/rtl/fdmus_cmd.sv @@
// ----------------------------------------------------------------------------
// fdmus_cmd
// serial command decoder: addressing, column fill and commit requests
// ----------------------------------------------------------------------------
module fdmus_cmd (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_en,
	input  logic [7:0]                          byte_value,
	input  logic [fdmus_pkg::ADDR_W-1:0]        module_address,
	input  logic                                commit_take,
	output fdmus_pkg::cmd_status_t              status
);

	logic [fdmus_pkg::DOTS-1:0]   target_q;
	logic [fdmus_pkg::SLOT_W-1:0] slot_q;
	logic                         addressed_q;
	logic                         pending_q;
	logic                         force_q;
	logic [fdmus_pkg::SLOT_W-1:0] byte_slot;

	assign byte_slot = byte_value[fdmus_pkg::SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			slot_q      <= '0;
			addressed_q <= 1'b0;
			pending_q   <= 1'b1;
			force_q     <= 1'b1;
		end else if (commit_take) begin
			pending_q <= 1'b0;
			force_q   <= 1'b0;
		end else if (byte_en) begin
			if (byte_value[7]) begin
				if (byte_value[6:4] == module_address) begin
					addressed_q <= 1'b1;
					slot_q      <= byte_slot;
					if (byte_slot == fdmus_pkg::SLOT_COMMIT) begin
						pending_q   <= 1'b1;
						addressed_q <= 1'b0;
					end
					if (byte_slot == fdmus_pkg::SLOT_REDRAW) begin
						pending_q   <= 1'b1;
						force_q     <= 1'b1;
						addressed_q <= 1'b0;
					end
				end else begin
					addressed_q <= 1'b0;
				end
			end else if (addressed_q && slot_q < fdmus_pkg::SLOT_W'(fdmus_pkg::COLUMNS)) begin
				for (int c = 0; c < fdmus_pkg::COLUMNS; c++) begin
					if (slot_q == fdmus_pkg::SLOT_W'(c))
						target_q[c*fdmus_pkg::ROWS +: fdmus_pkg::ROWS] <=
							byte_value[fdmus_pkg::ROWS-1:0];
				end
				// wrap after the last column
				if (slot_q == fdmus_pkg::SLOT_W'(fdmus_pkg::COLUMNS - 1))
					slot_q <= '0;
				else
					slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign status.target_dots    = target_q;
	assign status.commit_pending = pending_q;
	assign status.force_all      = force_q;

endmodule

@@ hw/rtl/fdmus_word.sv @@
// ----------------------------------------------------------------------------
// fdmus_word
// h-bridge drive word for one dot slot from the pin tables
// ----------------------------------------------------------------------------
module fdmus_word (
	input  logic [fdmus_pkg::DOT_IDX_W-1:0] dot_index,
	input  logic [fdmus_pkg::DOTS-1:0]      change_mask,
	input  logic [fdmus_pkg::DOTS-1:0]      pulse_values,
	output logic [fdmus_pkg::WORD_W-1:0]    word
);

	logic [fdmus_pkg::COL_W-1:0]     col;
	logic [fdmus_pkg::ROW_W-1:0]     row;
	logic [fdmus_pkg::DOT_IDX_W-1:0] col_base;
	logic                            in_range;

	assign in_range = dot_index < fdmus_pkg::DOT_IDX_W'(fdmus_pkg::DOTS);
	assign col      = fdmus_pkg::slot_col(dot_index);
	assign col_base = fdmus_pkg::DOT_IDX_W'(col * fdmus_pkg::ROWS);
	assign row      = fdmus_pkg::ROW_W'(dot_index - col_base);

	always_comb begin
		word = '0;
		if (in_range && change_mask[dot_index]) begin
			if (pulse_values[dot_index]) begin
				word = word | fdmus_pkg::pin_bit(fdmus_pkg::COL_LO_PIN[col]);
				word = word & ~fdmus_pkg::pin_bit(fdmus_pkg::COL_HI_PIN[col]);
				word = word | fdmus_pkg::pin_bit(fdmus_pkg::ROW_HI_PIN[row]);
				word = word & ~fdmus_pkg::pin_bit(fdmus_pkg::ROW_LO_PIN[row]);
			end else begin
				word = word | fdmus_pkg::pin_bit(fdmus_pkg::COL_HI_PIN[col]);
				word = word & ~fdmus_pkg::pin_bit(fdmus_pkg::COL_LO_PIN[col]);
				word = word | fdmus_pkg::pin_bit(fdmus_pkg::ROW_LO_PIN[row]);
				word = word & ~fdmus_pkg::pin_bit(fdmus_pkg::ROW_HI_PIN[row]);
			end
		end
	end

endmodule
